// ----- hdl/lidar_bev_height_density_map_unit_defines.svh -----
// ----------------------------------------------------------------------------
// lidar bev map unit assertion macros
// shared assertion forms, clocked on i_clk and disabled during i_rst_n low
// ----------------------------------------------------------------------------
`ifndef LIDAR_BEV_HEIGHT_DENSITY_MAP_UNIT_DEFINES_SVH
`define LIDAR_BEV_HEIGHT_DENSITY_MAP_UNIT_DEFINES_SVH

// same-cycle implication
`define BEV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BEV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bev_pkg.sv -----
// ----------------------------------------------------------------------------
// bev_pkg
// shared constants, types and the density table of the bev map unit
// ----------------------------------------------------------------------------
`default_nettype none

package bev_pkg;

    // grid geometry
    localparam int GRID_X = 1024;
    localparam int GRID_Y = 1024;
    localparam int SLICES = 5;
    localparam int CELLS  = GRID_X * GRID_Y;
    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int AW     = $clog2(CELLS);
    localparam int SLW    = (SLICES > 1) ? $clog2(SLICES) : 1;

    // field widths
    localparam int COORD_W = 18;
    localparam int SIZE_W  = 16;
    localparam int NCELL_W = 11;
    localparam int CH_W    = 3;
    localparam int CIDX_W  = 10;
    localparam int VAL_W   = 8;
    localparam int COUNT_W = 6;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 18;
    localparam int COUNT_SAT = 32;
    localparam int DENS_TOP  = 31;

    // bound products
    localparam int LIMX_W = NCELL_W + SIZE_W;
    localparam int LIMZ_W = SIZE_W + $clog2(SLICES + 1);

    // shared divider
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 18;
    localparam int DIV_QW = 11;
    localparam int DIV_KW = $clog2(DIV_QW + 1);
    localparam int DIV_SW = DIV_DW + DIV_QW - 1;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int QPW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_X_ORIGIN  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_Y_ORIGIN  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_Z_FLOOR   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_Z_CEILING = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CELL_SIZE = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SLICE_SZ  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_CELLS_X   = 3'd6;
    localparam logic [CFG_AW-1:0] REG_CELLS_Y   = 3'd7;

    // reset values
    localparam int RST_X_ORIGIN  = -30000;
    localparam int RST_Y_ORIGIN  = 0;
    localparam int RST_Z_FLOOR   = -2300;
    localparam int RST_Z_CEILING = 200;
    localparam int RST_CELL_SIZE = 100;
    localparam int RST_SLICE_SZ  = 500;
    localparam int RST_CELLS_X   = 600;
    localparam int RST_CELLS_Y   = 600;

    typedef struct packed {
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] y_origin;
        logic [COORD_W-1:0] z_floor;
        logic [COORD_W-1:0] z_ceiling;
        logic [SIZE_W-1:0]  cell_size;
        logic [SIZE_W-1:0]  slice_size;
        logic [NCELL_W-1:0] cells_x;
        logic [NCELL_W-1:0] cells_y;
        logic [LIMX_W-1:0]  lim_x;
        logic [LIMX_W-1:0]  lim_y;
        logic [LIMZ_W-1:0]  lim_z;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_ADD,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [AW-1:0]   row;
        logic [SLW-1:0]  slice;
        logic [VAL_W-1:0] height;
        logic [CH_W-1:0] channel;
        logic            hit;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0]              count;
        logic [SLICES-1:0][VAL_W-1:0]    height;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic [2:0] {
        F_IDLE,
        F_CHECK,
        F_DIV_X,
        F_DIV_Y,
        F_DIV_Z,
        F_DIV_H,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_MOD,
        B_RD
    } t_bstate;

    // floor(ln(2c) / 4.15888308336 * 255), saturated from 31 up
    function automatic logic [VAL_W-1:0] density_byte(input logic [COUNT_W-1:0] c);
        logic [VAL_W-1:0] v;
        case (c)
            6'd0:  v = 8'd0;
            6'd1:  v = 8'd42;
            6'd2:  v = 8'd84;
            6'd3:  v = 8'd109;
            6'd4:  v = 8'd127;
            6'd5:  v = 8'd141;
            6'd6:  v = 8'd152;
            6'd7:  v = 8'd161;
            6'd8:  v = 8'd169;
            6'd9:  v = 8'd177;
            6'd10: v = 8'd183;
            6'd11: v = 8'd189;
            6'd12: v = 8'd194;
            6'd13: v = 8'd199;
            6'd14: v = 8'd204;
            6'd15: v = 8'd208;
            6'd16: v = 8'd212;
            6'd17: v = 8'd216;
            6'd18: v = 8'd219;
            6'd19: v = 8'd223;
            6'd20: v = 8'd226;
            6'd21: v = 8'd229;
            6'd22: v = 8'd232;
            6'd23: v = 8'd234;
            6'd24: v = 8'd237;
            6'd25: v = 8'd239;
            6'd26: v = 8'd242;
            6'd27: v = 8'd244;
            6'd28: v = 8'd246;
            6'd29: v = 8'd248;
            6'd30: v = 8'd251;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lidar_bev_height_density_map_unit.sv -----
// ----------------------------------------------------------------------------
// lidar_bev_height_density_map_unit
// bird's-eye-view height and density map builder for lidar points
// ----------------------------------------------------------------------------
// Requests enter through a queue-style push/full port and read bytes leave
// through an empty/pop port. The front end holds one request at a time: a
// point is binned by one shared restoring divider that yields one quotient
// bit per cycle (11 bits for the x cell, 11 for the y cell, 3 for the
// slice, 8 for the height byte); clear and read requests skip the divider.
// A two-entry command queue lets the front end keep working while the back
// end is busy. The back end owns one memory row per xy cell (count plus all
// slice heights): a point is a read-modify-write of its row, a read fetches
// its row, and a clear sweeps all 1048576 rows, one per cycle. The same
// sweep runs after reset; during it requests still enter until the command
// queue and the front end are full. Configuration is written through
// i_cfg_we/i_cfg_addr/i_cfg_wdata; the user must do so only while no
// request is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lidar_bev_height_density_map_unit_defines.svh"

module lidar_bev_height_density_map_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [bev_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [bev_pkg::CFG_DW-1:0]     i_cfg_wdata,
    // request side
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     i_action,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_x_mm,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_y_mm,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_z_mm,
    input  wire logic [bev_pkg::CH_W-1:0]       i_channel,
    input  wire logic [bev_pkg::CIDX_W-1:0]     i_cell_x,
    input  wire logic [bev_pkg::CIDX_W-1:0]     i_cell_y,
    // result side
    output logic                                empty,
    input  wire logic                           pop,
    output logic [bev_pkg::VAL_W-1:0]           o_value
);

    bev_pkg::t_cfg                r_cfg;

    // command queue between front and back
    bev_pkg::t_cmd                r_qmem [bev_pkg::Q_DEPTH];
    logic [bev_pkg::QPW-1:0]      r_wp, r_rp;
    logic [bev_pkg::QCW-1:0]      r_q_cnt;
    logic                         q_push, q_pop, q_full, q_empty;
    bev_pkg::t_cmd                q_in;

    // configuration registers; bound products registered behind them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin   <= bev_pkg::COORD_W'(bev_pkg::RST_X_ORIGIN);
            r_cfg.y_origin   <= bev_pkg::COORD_W'(bev_pkg::RST_Y_ORIGIN);
            r_cfg.z_floor    <= bev_pkg::COORD_W'(bev_pkg::RST_Z_FLOOR);
            r_cfg.z_ceiling  <= bev_pkg::COORD_W'(bev_pkg::RST_Z_CEILING);
            r_cfg.cell_size  <= bev_pkg::SIZE_W'(bev_pkg::RST_CELL_SIZE);
            r_cfg.slice_size <= bev_pkg::SIZE_W'(bev_pkg::RST_SLICE_SZ);
            r_cfg.cells_x    <= bev_pkg::NCELL_W'(bev_pkg::RST_CELLS_X);
            r_cfg.cells_y    <= bev_pkg::NCELL_W'(bev_pkg::RST_CELLS_Y);
            r_cfg.lim_x      <= bev_pkg::LIMX_W'(bev_pkg::RST_CELLS_X * bev_pkg::RST_CELL_SIZE);
            r_cfg.lim_y      <= bev_pkg::LIMX_W'(bev_pkg::RST_CELLS_Y * bev_pkg::RST_CELL_SIZE);
            r_cfg.lim_z      <= bev_pkg::LIMZ_W'(bev_pkg::SLICES * bev_pkg::RST_SLICE_SZ);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bev_pkg::REG_X_ORIGIN:  r_cfg.x_origin   <= i_cfg_wdata;
                    bev_pkg::REG_Y_ORIGIN:  r_cfg.y_origin   <= i_cfg_wdata;
                    bev_pkg::REG_Z_FLOOR:   r_cfg.z_floor    <= i_cfg_wdata;
                    bev_pkg::REG_Z_CEILING: r_cfg.z_ceiling  <= i_cfg_wdata;
                    bev_pkg::REG_CELL_SIZE: r_cfg.cell_size  <= i_cfg_wdata[bev_pkg::SIZE_W-1:0];
                    bev_pkg::REG_SLICE_SZ:  r_cfg.slice_size <= i_cfg_wdata[bev_pkg::SIZE_W-1:0];
                    bev_pkg::REG_CELLS_X:   r_cfg.cells_x    <= i_cfg_wdata[bev_pkg::NCELL_W-1:0];
                    bev_pkg::REG_CELLS_Y:   r_cfg.cells_y    <= i_cfg_wdata[bev_pkg::NCELL_W-1:0];
                    default: ;
                endcase
            end
            // box extents in millimetres
            r_cfg.lim_x <= bev_pkg::LIMX_W'(r_cfg.cells_x) * bev_pkg::LIMX_W'(r_cfg.cell_size);
            r_cfg.lim_y <= bev_pkg::LIMX_W'(r_cfg.cells_y) * bev_pkg::LIMX_W'(r_cfg.cell_size);
            r_cfg.lim_z <= bev_pkg::LIMZ_W'(bev_pkg::SLICES)
                         * bev_pkg::LIMZ_W'(r_cfg.slice_size);
        end
    end

    // command queue
    assign q_full  = (r_q_cnt == bev_pkg::QCW'(bev_pkg::Q_DEPTH));
    assign q_empty = (r_q_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_wp <= r_wp + bev_pkg::QPW'(1);
            end
            if (q_pop) begin
                r_rp <= r_rp + bev_pkg::QPW'(1);
            end
            if (q_push && !q_pop) begin
                r_q_cnt <= r_q_cnt + bev_pkg::QCW'(1);
            end else if (q_pop && !q_push) begin
                r_q_cnt <= r_q_cnt - bev_pkg::QCW'(1);
            end
        end
        if (q_push) begin
            r_qmem[r_wp] <= q_in;
        end
    end

    // front: request intake, box check, binning
    bev_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_action   (i_action),
        .i_x_mm     (i_x_mm),
        .i_y_mm     (i_y_mm),
        .i_z_mm     (i_z_mm),
        .i_channel  (i_channel),
        .i_cell_x   (i_cell_x),
        .i_cell_y   (i_cell_y),
        .o_cmd_push (q_push),
        .o_cmd      (q_in),
        .i_cmd_full (q_full)
    );

    // back: memory sweep, point update, byte read
    bev_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (r_qmem[r_rp]),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_value     (o_value)
    );

    `BEV_ASSERT_IMP(a_q_no_underflow, q_pop, r_q_cnt != '0, "pop from empty command queue")
    `BEV_ASSERT_IMP(a_q_no_overflow, q_push, !q_full || q_pop, "push into full command queue")
    `BEV_ASSERT_NXT(a_front_busy, push && !full, full, "front not busy after request")
    `BEV_ASSERT_NXT(a_result_taken, pop && !empty, empty, "result slot refilled while taken")

endmodule

`default_nettype wire

// ----- hdl/bev_ram.sv -----
// ----------------------------------------------------------------------------
// bev_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bev_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/bev_div.sv -----
// ----------------------------------------------------------------------------
// bev_div
// restoring divider, one quotient bit per cycle, quotient length per request
// ----------------------------------------------------------------------------
`default_nettype none

module bev_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bev_pkg::DIV_NW-1:0]    i_num,
    input  wire logic [bev_pkg::DIV_DW-1:0]    i_den,
    input  wire logic [bev_pkg::DIV_KW-1:0]    i_qbits,
    output logic                               o_done,
    output logic      [bev_pkg::DIV_QW-1:0]    o_quo
);

    logic                         r_busy;
    logic                         r_done;
    logic [bev_pkg::DIV_KW-1:0]   r_k;
    logic [bev_pkg::DIV_NW-1:0]   r_rem;
    logic [bev_pkg::DIV_SW-1:0]   r_den;
    logic [bev_pkg::DIV_QW-1:0]   r_q;
    logic                         ge;

    // the caller keeps the quotient inside i_qbits bits
    assign ge = {{(bev_pkg::DIV_SW - bev_pkg::DIV_NW){1'b0}}, r_rem} >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem <= i_num;
            r_den <= bev_pkg::DIV_SW'(i_den) << (i_qbits - bev_pkg::DIV_KW'(1));
            r_k   <= i_qbits - bev_pkg::DIV_KW'(1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den[bev_pkg::DIV_NW-1:0];
            end
            r_den <= r_den >> 1;
            r_k   <= r_k - bev_pkg::DIV_KW'(1);
            r_q   <= {r_q[bev_pkg::DIV_QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

// ----- hdl/bev_front.sv -----
// ----------------------------------------------------------------------------
// bev_front
// takes requests, checks the box, bins points and queues map commands
// ----------------------------------------------------------------------------
`default_nettype none

module bev_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bev_pkg::t_cfg                  i_cfg,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic [1:0]                     i_action,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_x_mm,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_y_mm,
    input  wire logic [bev_pkg::COORD_W-1:0]    i_z_mm,
    input  wire logic [bev_pkg::CH_W-1:0]       i_channel,
    input  wire logic [bev_pkg::CIDX_W-1:0]     i_cell_x,
    input  wire logic [bev_pkg::CIDX_W-1:0]     i_cell_y,
    output logic                                o_cmd_push,
    output bev_pkg::t_cmd                       o_cmd,
    input  wire logic                           i_cmd_full
);

    bev_pkg::t_fstate              r_state, n_state;
    logic [1:0]                    r_action, n_action;
    logic [bev_pkg::COORD_W-1:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic [bev_pkg::CH_W-1:0]      r_ch, n_ch;
    logic [bev_pkg::CIDX_W-1:0]    r_cx, n_cx, r_cy, n_cy;
    logic [bev_pkg::DIV_DW-1:0]    r_dy, n_dy, r_dz, n_dz, r_span, n_span;
    logic [bev_pkg::XW-1:0]        r_xi, n_xi;
    logic [bev_pkg::YW-1:0]        r_yi, n_yi;
    logic [bev_pkg::SLW-1:0]       r_zi, n_zi;
    bev_pkg::t_cmd                 r_cmd, n_cmd;

    logic                          div_start, div_done;
    logic [bev_pkg::DIV_NW-1:0]    div_num;
    logic [bev_pkg::DIV_DW-1:0]    div_den;
    logic [bev_pkg::DIV_KW-1:0]    div_qbits;
    logic [bev_pkg::DIV_QW-1:0]    div_quo;

    logic signed [bev_pkg::COORD_W:0] dx, dy, dz, span;
    logic                          z_ok, xy_ok, add_ok, rd_hit;
    logic [bev_pkg::DIV_NW-1:0]    h_num;

    // box check on the held point
    always_comb begin
        dx   = $signed({r_x[bev_pkg::COORD_W-1], r_x})
             - $signed({i_cfg.x_origin[bev_pkg::COORD_W-1], i_cfg.x_origin});
        dy   = $signed({r_y[bev_pkg::COORD_W-1], r_y})
             - $signed({i_cfg.y_origin[bev_pkg::COORD_W-1], i_cfg.y_origin});
        dz   = $signed({r_z[bev_pkg::COORD_W-1], r_z})
             - $signed({i_cfg.z_floor[bev_pkg::COORD_W-1], i_cfg.z_floor});
        span = $signed({i_cfg.z_ceiling[bev_pkg::COORD_W-1], i_cfg.z_ceiling})
             - $signed({i_cfg.z_floor[bev_pkg::COORD_W-1], i_cfg.z_floor});
        z_ok = !dz[bev_pkg::COORD_W]
            && ($signed(r_z) < $signed(i_cfg.z_ceiling))
            && (bev_pkg::LIMZ_W'(dz[bev_pkg::COORD_W-1:0]) < i_cfg.lim_z);
        xy_ok = !dx[bev_pkg::COORD_W] && !dy[bev_pkg::COORD_W]
            && (bev_pkg::LIMX_W'(dx[bev_pkg::COORD_W-1:0]) < i_cfg.lim_x)
            && (bev_pkg::LIMX_W'(dy[bev_pkg::COORD_W-1:0]) < i_cfg.lim_y);
        add_ok = (i_cfg.cell_size != '0) && (i_cfg.slice_size != '0) && z_ok && xy_ok;
        rd_hit = (32'(r_ch) <= bev_pkg::SLICES) && (32'(r_cx) < bev_pkg::GRID_X)
            && (32'(r_cy) < bev_pkg::GRID_Y);
        // dz * 255
        h_num = (bev_pkg::DIV_NW'(r_dz) << 8) - bev_pkg::DIV_NW'(r_dz);
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_ch      = r_ch;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_dy      = r_dy;
        n_dz      = r_dz;
        n_span    = r_span;
        n_xi      = r_xi;
        n_yi      = r_yi;
        n_zi      = r_zi;
        n_cmd     = r_cmd;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_qbits = '0;
        o_cmd_push = 1'b0;
        case (r_state)
            bev_pkg::F_IDLE: begin
                if (i_push) begin
                    n_action = i_action;
                    n_x      = i_x_mm;
                    n_y      = i_y_mm;
                    n_z      = i_z_mm;
                    n_ch     = i_channel;
                    n_cx     = i_cell_x;
                    n_cy     = i_cell_y;
                    n_state  = bev_pkg::F_CHECK;
                end
            end
            bev_pkg::F_CHECK: begin
                n_cmd = '0;
                case (r_action)
                    bev_pkg::ACT_CLEAR: begin
                        n_cmd.op = bev_pkg::OP_CLEAR;
                        n_state  = bev_pkg::F_PUSH;
                    end
                    bev_pkg::ACT_READ: begin
                        n_cmd.op      = bev_pkg::OP_READ;
                        n_cmd.hit     = rd_hit;
                        n_cmd.channel = r_ch;
                        n_cmd.row     = bev_pkg::AW'(r_cy) * bev_pkg::AW'(bev_pkg::GRID_X)
                                      + bev_pkg::AW'(r_cx);
                        n_state       = bev_pkg::F_PUSH;
                    end
                    bev_pkg::ACT_ADD: begin
                        if (add_ok) begin
                            n_dy      = dy[bev_pkg::DIV_DW-1:0];
                            n_dz      = dz[bev_pkg::DIV_DW-1:0];
                            n_span    = span[bev_pkg::DIV_DW-1:0];
                            div_start = 1'b1;
                            div_num   = bev_pkg::DIV_NW'(dx[bev_pkg::DIV_DW-1:0]);
                            div_den   = bev_pkg::DIV_DW'(i_cfg.cell_size);
                            div_qbits = bev_pkg::DIV_KW'(bev_pkg::DIV_QW);
                            n_state   = bev_pkg::F_DIV_X;
                        end else begin
                            n_state = bev_pkg::F_IDLE;
                        end
                    end
                    default: n_state = bev_pkg::F_IDLE;
                endcase
            end
            bev_pkg::F_DIV_X: begin
                if (div_done) begin
                    if (32'(div_quo) < bev_pkg::GRID_X) begin
                        n_xi      = bev_pkg::XW'(div_quo);
                        div_start = 1'b1;
                        div_num   = bev_pkg::DIV_NW'(r_dy);
                        div_den   = bev_pkg::DIV_DW'(i_cfg.cell_size);
                        div_qbits = bev_pkg::DIV_KW'(bev_pkg::DIV_QW);
                        n_state   = bev_pkg::F_DIV_Y;
                    end else begin
                        n_state = bev_pkg::F_IDLE;
                    end
                end
            end
            bev_pkg::F_DIV_Y: begin
                if (div_done) begin
                    if (32'(div_quo) < bev_pkg::GRID_Y) begin
                        n_yi      = bev_pkg::YW'(div_quo);
                        div_start = 1'b1;
                        div_num   = bev_pkg::DIV_NW'(r_dz);
                        div_den   = bev_pkg::DIV_DW'(i_cfg.slice_size);
                        div_qbits = bev_pkg::DIV_KW'(bev_pkg::SLW);
                        n_state   = bev_pkg::F_DIV_Z;
                    end else begin
                        n_state = bev_pkg::F_IDLE;
                    end
                end
            end
            bev_pkg::F_DIV_Z: begin
                if (div_done) begin
                    n_zi      = div_quo[bev_pkg::SLW-1:0];
                    div_start = 1'b1;
                    div_num   = h_num;
                    div_den   = r_span;
                    div_qbits = bev_pkg::DIV_KW'(bev_pkg::VAL_W);
                    n_state   = bev_pkg::F_DIV_H;
                end
            end
            bev_pkg::F_DIV_H: begin
                if (div_done) begin
                    n_cmd        = '0;
                    n_cmd.op     = bev_pkg::OP_ADD;
                    n_cmd.row    = bev_pkg::AW'(r_yi) * bev_pkg::AW'(bev_pkg::GRID_X)
                                 + bev_pkg::AW'(r_xi);
                    n_cmd.slice  = r_zi;
                    n_cmd.height = div_quo[bev_pkg::VAL_W-1:0];
                    n_state      = bev_pkg::F_PUSH;
                end
            end
            bev_pkg::F_PUSH: begin
                if (!i_cmd_full) begin
                    o_cmd_push = 1'b1;
                    n_state    = bev_pkg::F_IDLE;
                end
            end
            default: n_state = bev_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bev_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_action <= n_action;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_ch     <= n_ch;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_dy     <= n_dy;
        r_dz     <= n_dz;
        r_span   <= n_span;
        r_xi     <= n_xi;
        r_yi     <= n_yi;
        r_zi     <= n_zi;
        r_cmd    <= n_cmd;
    end

    assign o_full = (r_state != bev_pkg::F_IDLE);
    assign o_cmd  = r_cmd;

    bev_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_qbits (div_qbits),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

endmodule

`default_nettype wire

// ----- hdl/bev_back.sv -----
// ----------------------------------------------------------------------------
// bev_back
// runs map commands against the cell memory and holds the read result
// ----------------------------------------------------------------------------
`default_nettype none

module bev_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_empty,
    input  wire bev_pkg::t_cmd              i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [bev_pkg::VAL_W-1:0]       o_value
);

    bev_pkg::t_bstate             r_state, n_state;
    logic [bev_pkg::AW-1:0]       r_addr, n_addr;
    bev_pkg::t_cmd                r_cmd, n_cmd;
    logic                         r_out_valid, n_out_valid;
    logic [bev_pkg::VAL_W-1:0]    r_out_value, n_out_value;

    logic                         ram_we;
    logic [bev_pkg::AW-1:0]       ram_waddr, ram_raddr;
    bev_pkg::t_row                ram_wdata, ram_rdata, upd;

    always_comb begin
        upd = ram_rdata;
        if (32'(ram_rdata.count) < bev_pkg::COUNT_SAT) begin
            upd.count = ram_rdata.count + bev_pkg::COUNT_W'(1);
        end
        if (r_cmd.height > ram_rdata.height[r_cmd.slice]) begin
            upd.height[r_cmd.slice] = r_cmd.height;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_raddr   = i_cmd.row;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            bev_pkg::B_SWEEP: begin
                ram_we = 1'b1;
                n_addr = r_addr + bev_pkg::AW'(1);
                if (r_addr == bev_pkg::AW'(bev_pkg::CELLS - 1)) begin
                    n_state = bev_pkg::B_IDLE;
                end
            end
            bev_pkg::B_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        bev_pkg::OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_addr    = '0;
                            n_state   = bev_pkg::B_SWEEP;
                        end
                        bev_pkg::OP_ADD: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            n_state   = bev_pkg::B_MOD;
                        end
                        bev_pkg::OP_READ: begin
                            // result slot must be free
                            if (!r_out_valid) begin
                                o_cmd_pop = 1'b1;
                                n_cmd     = i_cmd;
                                n_state   = bev_pkg::B_RD;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            bev_pkg::B_MOD: begin
                ram_we    = 1'b1;
                ram_waddr = r_cmd.row;
                ram_wdata = upd;
                n_state   = bev_pkg::B_IDLE;
            end
            bev_pkg::B_RD: begin
                if (!r_cmd.hit) begin
                    n_out_value = '0;
                end else if (32'(r_cmd.channel) == bev_pkg::SLICES) begin
                    n_out_value = bev_pkg::density_byte(ram_rdata.count);
                end else begin
                    n_out_value = ram_rdata.height[r_cmd.channel[bev_pkg::SLW-1:0]];
                end
                n_out_valid = 1'b1;
                n_state     = bev_pkg::B_IDLE;
            end
            default: n_state = bev_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bev_pkg::B_SWEEP;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_out_value <= n_out_value;
    end

    assign o_empty = !r_out_valid;
    assign o_value = r_out_value;

    bev_ram #(
        .WIDTH (bev_pkg::ROW_W),
        .DEPTH (bev_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
